/* src/deque_with_search_count_assert.svh */
// Assertion macros used by the deque datapath.
`ifndef DEQUE_WITH_SEARCH_COUNT_ASSERT_SVH
`define DEQUE_WITH_SEARCH_COUNT_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define DQSC_ASSERT_IMPLIES(name, clock, rstn, ante, cons) \
    name: assert property (@(posedge clock) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("deque: same-cycle check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define DQSC_ASSERT_NEXT(name, clock, rstn, ante, cons) \
    name: assert property (@(posedge clock) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("deque: next-cycle check failed");

`endif

/* src/dqsc_pkg.sv */
// Types and codes shared by the deque controller, datapath and top level.
`default_nettype none

package dqsc_pkg;

    typedef enum logic [2:0] {
        KIND_PUSH_BACK  = 3'd0,
        KIND_PUSH_FRONT = 3'd1,
        KIND_POP_BACK   = 3'd2,
        KIND_POP_FRONT  = 3'd3,
        KIND_COUNT      = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        RES_ZERO  = 2'd0,
        RES_READ  = 2'd1,
        RES_MATCH = 2'd2
    } res_sel_t;

    typedef enum logic [2:0] {
        S_IDLE   = 3'd0,
        S_EXEC   = 3'd1,
        S_SCAN   = 3'd2,
        S_TAIL   = 3'd3,
        S_FINISH = 3'd4
    } state_t;

    typedef struct packed {
        logic     capture;
        logic     push_back;
        logic     push_front;
        logic     pop_back;
        logic     pop_front;
        logic     scan_start;
        logic     scan_step;
        logic     load_out;
        logic     refuse;
        res_sel_t res_sel;
    } dqsc_cmd_t;

    typedef struct packed {
        logic [2:0] kind;
        logic       full;
        logic       empty;
        logic       scan_last;
    } dqsc_status_t;

endpackage

`default_nettype wire

/* src/dqsc_dpath.sv */
// Datapath of the deque: ring memory, pointers, search counter and result register.
`default_nettype none
`include "deque_with_search_count_assert.svh"

module dqsc_dpath #(
    parameter int DEPTH = 64
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire dqsc_pkg::dqsc_cmd_t        cmd,
    output dqsc_pkg::dqsc_status_t          status,
    input  wire logic [2:0]                 kind,
    input  wire logic signed [31:0]         value,
    output logic signed [31:0]              result_value,
    output logic                            refused,
    output logic [$clog2(DEPTH+1)-1:0]      occupancy
);
    import dqsc_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW:0]   DEPTH_W = (AW + 1)'(DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

    logic [31:0]       mem [DEPTH];
    logic [AW-1:0]     front_reg, front_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [AW-1:0]     scan_idx_reg, scan_idx_next;
    logic [CW-1:0]     match_reg, match_next;
    logic              cmp_v_reg;
    logic [2:0]        kind_reg;
    logic [31:0]       key_reg;
    logic [31:0]       rd_data_reg;
    logic [AW-1:0]     rd_addr;
    logic              rd_en;
    logic [AW-1:0]     wr_addr;
    logic              wr_en;
    logic [AW-1:0]     front_dec;
    logic [CW-1:0]     count_dec;
    logic signed [31:0] out_value_reg;
    logic              out_refused_reg;
    logic [CW-1:0]     out_occ_reg;

    // Adds two ring indices modulo DEPTH; both inputs are below DEPTH.
    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a,
                                               input logic [AW-1:0] b);
        logic [AW:0] s;
        logic [AW:0] d;
        s = {1'b0, a} + {1'b0, b};
        d = s - DEPTH_W;
        return (s >= DEPTH_W) ? d[AW-1:0] : s[AW-1:0];
    endfunction

    assign front_dec = (front_reg == '0) ? LAST_IDX : front_reg - 1'b1;
    assign count_dec = count_reg - 1'b1;

    always_comb
    begin
        wr_en   = cmd.push_back || cmd.push_front;
        wr_addr = cmd.push_front ? front_dec : wrap_add(front_reg, count_reg[AW-1:0]);
        rd_en   = cmd.pop_back || cmd.pop_front || cmd.scan_step;
        if (cmd.pop_back)
        begin
            rd_addr = wrap_add(front_reg, count_dec[AW-1:0]);
        end
        else if (cmd.pop_front)
        begin
            rd_addr = front_reg;
        end
        else
        begin
            rd_addr = wrap_add(front_reg, scan_idx_reg);
        end
    end

    always_comb
    begin
        front_next    = front_reg;
        count_next    = count_reg;
        scan_idx_next = scan_idx_reg;
        match_next    = match_reg;
        if (cmd.push_back)
        begin
            count_next = count_reg + 1'b1;
        end
        if (cmd.push_front)
        begin
            front_next = front_dec;
            count_next = count_reg + 1'b1;
        end
        if (cmd.pop_back)
        begin
            count_next = count_dec;
        end
        if (cmd.pop_front)
        begin
            front_next = wrap_add(front_reg, AW'(1));
            count_next = count_dec;
        end
        if (cmd.scan_start)
        begin
            scan_idx_next = '0;
            match_next    = '0;
        end
        else
        begin
            if (cmd.scan_step)
            begin
                scan_idx_next = scan_idx_reg + 1'b1;
            end
            // The compare happens in the cycle after the read because the memory
            // output is registered.
            if (cmp_v_reg && (rd_data_reg == key_reg))
            begin
                match_next = match_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg    <= '0;
            count_reg    <= '0;
            scan_idx_reg <= '0;
            match_reg    <= '0;
            cmp_v_reg    <= 1'b0;
        end
        else
        begin
            front_reg    <= front_next;
            count_reg    <= count_next;
            scan_idx_reg <= scan_idx_next;
            match_reg    <= match_next;
            cmp_v_reg    <= cmd.scan_step;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= key_reg;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg <= kind;
            key_reg  <= value;
        end
        if (cmd.load_out)
        begin
            case (cmd.res_sel)
                RES_READ:  out_value_reg <= rd_data_reg;
                RES_MATCH: out_value_reg <= 32'(match_reg);
                default:   out_value_reg <= '0;
            endcase
            out_refused_reg <= cmd.refuse;
            out_occ_reg     <= count_reg;
        end
    end

    assign status.kind      = kind_reg;
    assign status.full      = (count_reg == DEPTH_W[CW-1:0]);
    assign status.empty     = (count_reg == '0);
    assign status.scan_last = (CW'(scan_idx_reg) == count_dec);

    assign result_value = out_value_reg;
    assign refused      = out_refused_reg;
    assign occupancy    = out_occ_reg;

    `DQSC_ASSERT_IMPLIES(a_count_bound, clk, rst_n, 1'b1, count_reg <= DEPTH_W[CW-1:0])
    `DQSC_ASSERT_IMPLIES(a_no_push_full, clk, rst_n, wr_en, !status.full)
    `DQSC_ASSERT_IMPLIES(a_no_pop_empty, clk, rst_n, cmd.pop_back || cmd.pop_front, !status.empty)
    `DQSC_ASSERT_IMPLIES(a_scan_in_range, clk, rst_n, cmd.scan_step, CW'(scan_idx_reg) < count_reg)
    `DQSC_ASSERT_NEXT(a_push_grows, clk, rst_n, wr_en, count_reg == $past(count_reg) + 1'b1)

endmodule

`default_nettype wire

/* src/dqsc_ctrl.sv */
// Controller state machine that sequences each deque request.
`default_nettype none

module dqsc_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    input  wire dqsc_pkg::dqsc_status_t status,
    output dqsc_pkg::dqsc_cmd_t         cmd
);
    import dqsc_pkg::*;

    state_t   state_reg, state_next;
    res_sel_t res_sel_reg, res_sel_next;
    logic     refuse_reg, refuse_next;
    logic     out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_sel_reg   <= RES_ZERO;
            refuse_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_sel_reg   <= res_sel_next;
            refuse_reg    <= refuse_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        res_sel_next   = res_sel_reg;
        refuse_next    = refuse_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        cmd.res_sel    = res_sel_reg;
        cmd.refuse     = refuse_reg;
        in_stall       = (state_reg != S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                res_sel_next = RES_ZERO;
                refuse_next  = 1'b0;
                state_next   = S_FINISH;
                case (status.kind)
                    KIND_PUSH_BACK:
                    begin
                        if (status.full)
                        begin
                            refuse_next = 1'b1;
                        end
                        else
                        begin
                            cmd.push_back = 1'b1;
                        end
                    end
                    KIND_PUSH_FRONT:
                    begin
                        if (status.full)
                        begin
                            refuse_next = 1'b1;
                        end
                        else
                        begin
                            cmd.push_front = 1'b1;
                        end
                    end
                    KIND_POP_BACK:
                    begin
                        if (status.empty)
                        begin
                            refuse_next = 1'b1;
                        end
                        else
                        begin
                            cmd.pop_back = 1'b1;
                            res_sel_next = RES_READ;
                        end
                    end
                    KIND_POP_FRONT:
                    begin
                        if (status.empty)
                        begin
                            refuse_next = 1'b1;
                        end
                        else
                        begin
                            cmd.pop_front = 1'b1;
                            res_sel_next  = RES_READ;
                        end
                    end
                    KIND_COUNT:
                    begin
                        cmd.scan_start = 1'b1;
                        res_sel_next   = RES_MATCH;
                        if (!status.empty)
                        begin
                            state_next = S_SCAN;
                        end
                    end
                    default:
                    begin
                        refuse_next = 1'b1;
                    end
                endcase
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_last)
                begin
                    state_next = S_TAIL;
                end
            end
            S_TAIL:
            begin
                // The last entry read is compared during this cycle.
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

/* src/deque_with_search_count.sv */
// Top level of the bounded double-ended queue with match counting.
`default_nettype none

// Bounded deque of DEPTH signed 32-bit entries in a ring memory. Each input
// item pushes or pops at either end or counts the entries equal to value; each
// produces exactly one result item carrying the popped value or match count,
// a refused flag (pop on empty, push on full, unused kind code) and the
// occupancy after the request. Items are handled one at a time by a state
// machine over a memory with registered read: a push, a pop or a refused
// request passes from acceptance in S_IDLE through S_EXEC and S_FINISH, and a
// count on a nonempty queue also passes through S_SCAN, where the search reads
// one entry per cycle, and S_TAIL; on an empty queue it skips both. A
// finished result waits in an output register, so the next item is taken
// while the previous result is still stalled; that next item then holds its
// own result in S_FINISH until the register is free. The memory needs no
// clearing after reset; the block accepts items from the first cycle.
module deque_with_search_count #(
    parameter int DEPTH = 64
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [2:0]             kind,
    input  wire logic signed [31:0]     value,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic signed [31:0]          result_value,
    output logic                        refused,
    output logic [$clog2(DEPTH+1)-1:0]  occupancy
);
    import dqsc_pkg::*;

    dqsc_cmd_t    cmd;
    dqsc_status_t status;

    dqsc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    dqsc_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .kind         (kind),
        .value        (value),
        .result_value (result_value),
        .refused      (refused),
        .occupancy    (occupancy)
    );

endmodule

`default_nettype wire

/* sim/tb.sv */
// Self-checking testbench for the bounded deque with match counting.
`timescale 1ns / 100ps

module tb;

    import dqsc_pkg::*;

    localparam int QUEUE_DEPTH = 64;
    localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);
    localparam int CYCLE_LIMIT = 1_000_000;

    // Unused kind codes, which the block refuses.
    localparam logic [2:0] KIND_SPARE_A = 3'd5;
    localparam logic [2:0] KIND_SPARE_B = 3'd6;
    localparam logic [2:0] KIND_SPARE_C = 3'd7;

    localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic               refused;
        logic [OCC_W-1:0]   occupancy;
    } deque_result_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic [2:0]               kind = KIND_PUSH_BACK;
    logic signed [31:0]       value = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic signed [31:0]       result_value;
    logic                     refused;
    logic [OCC_W-1:0]         occupancy;

    // Shadow copy of the queue contents, front index and entry count.
    logic signed [31:0]       shadow_store [QUEUE_DEPTH];
    int                       shadow_front = 0;
    int                       shadow_count = 0;

    deque_result_t            pending_results [$];
    int                       error_count = 0;
    int                       cycle_count = 0;
    bit                       no_gaps = 1'b0;
    int                       stall_hold = 0;
    bit                       stall_on = 1'b0;

    deque_with_search_count #(
        .DEPTH(QUEUE_DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .kind(kind),
        .value(value),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .result_value(result_value),
        .refused(refused),
        .occupancy(occupancy)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 88)
            return int'($urandom_range(1, 3));
        else if (r < 97)
            return int'($urandom_range(4, 10));
        else
            return int'($urandom_range(20, 40));
    endfunction

    // Applies one request to the shadow queue and returns the result it must produce.
    function automatic deque_result_t apply_request(logic [2:0] k, logic signed [31:0] v);
        deque_result_t r;
        int i;
        r.result_value = '0;
        r.refused = 1'b0;
        case (k)
            KIND_PUSH_BACK:
                if (shadow_count >= QUEUE_DEPTH)
                    r.refused = 1'b1;
                else
                begin
                    shadow_store[(shadow_front + shadow_count) % QUEUE_DEPTH] = v;
                    shadow_count++;
                end
            KIND_PUSH_FRONT:
                if (shadow_count >= QUEUE_DEPTH)
                    r.refused = 1'b1;
                else
                begin
                    shadow_front = (shadow_front + QUEUE_DEPTH - 1) % QUEUE_DEPTH;
                    shadow_store[shadow_front] = v;
                    shadow_count++;
                end
            KIND_POP_BACK:
                if (shadow_count == 0)
                    r.refused = 1'b1;
                else
                begin
                    r.result_value =
                        shadow_store[(shadow_front + shadow_count - 1) % QUEUE_DEPTH];
                    shadow_count--;
                end
            KIND_POP_FRONT:
                if (shadow_count == 0)
                    r.refused = 1'b1;
                else
                begin
                    r.result_value = shadow_store[shadow_front];
                    shadow_front = (shadow_front + 1) % QUEUE_DEPTH;
                    shadow_count--;
                end
            KIND_COUNT:
                for (i = 0; i < shadow_count; i++)
                    if (shadow_store[(shadow_front + i) % QUEUE_DEPTH] == v)
                        r.result_value++;
            default:
                r.refused = 1'b1;
        endcase
        r.occupancy = OCC_W'(shadow_count);
        return r;
    endfunction

    // A narrow pool of values makes searches find several matches.
    function automatic logic signed [31:0] pick_value(bit for_search);
        int r;
        r = $urandom_range(0, 99);
        if (for_search && shadow_count > 0 && r < 40)
            return shadow_store[(shadow_front + $urandom_range(0, shadow_count - 1))
                                % QUEUE_DEPTH];
        else if (r < 60)
            return 32'(int'($urandom_range(0, 6)) - 3);
        else if (r < 70)
        begin
            case ($urandom_range(0, 3))
                0: return VAL_MIN;
                1: return VAL_MAX;
                2: return '0;
                default: return -32'sd1;
            endcase
        end
        else
            return $urandom();
    endfunction

    function automatic logic [2:0] pick_kind(int push_pct, int pop_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < push_pct)
            return ($urandom_range(0, 1) == 0) ? KIND_PUSH_BACK : KIND_PUSH_FRONT;
        else if (r < push_pct + pop_pct)
            return ($urandom_range(0, 1) == 0) ? KIND_POP_BACK : KIND_POP_FRONT;
        else if (r < 97)
            return KIND_COUNT;
        case ($urandom_range(0, 2))
            0: return KIND_SPARE_A;
            1: return KIND_SPARE_B;
            default: return KIND_SPARE_C;
        endcase
    endfunction

    task automatic send_request(input logic [2:0] k, input logic signed [31:0] v);
        int gap;
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind <= k;
        value <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_results.push_back(apply_request(k, v));
    endtask

    task automatic send_random(input int push_pct, input int pop_pct);
        logic [2:0] k;
        k = pick_kind(push_pct, pop_pct);
        send_request(k, pick_value(k == KIND_COUNT));
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Empty-queue refusals, spare codes, extreme values and searches on a short queue.
    task automatic test_corner_cases();
        send_request(KIND_POP_BACK, -32'sd1);
        send_request(KIND_POP_FRONT, VAL_MAX);
        send_request(KIND_COUNT, '0);
        send_request(KIND_SPARE_A, -32'sd1);
        send_request(KIND_SPARE_B, VAL_MIN);
        send_request(KIND_SPARE_C, VAL_MAX);
        send_request(KIND_PUSH_BACK, VAL_MIN);
        send_request(KIND_PUSH_FRONT, VAL_MAX);
        send_request(KIND_PUSH_BACK, '0);
        send_request(KIND_PUSH_FRONT, -32'sd1);
        send_request(KIND_PUSH_BACK, VAL_MIN);
        send_request(KIND_COUNT, VAL_MIN);
        send_request(KIND_COUNT, VAL_MAX);
        send_request(KIND_COUNT, '0);
        send_request(KIND_COUNT, 32'sd12345);
        send_request(KIND_SPARE_A, '0);
        send_request(KIND_POP_FRONT, '0);
        send_request(KIND_POP_BACK, '0);
        send_request(KIND_POP_FRONT, '0);
        send_request(KIND_POP_BACK, '0);
        send_request(KIND_POP_FRONT, '0);
        send_request(KIND_POP_FRONT, '0);
        send_request(KIND_PUSH_FRONT, 32'sh5555_5555);
        send_request(KIND_PUSH_BACK, 32'shAAAA_AAAA);
    endtask

    // Push-heavy traffic runs the queue into full and keeps pushing into it.
    task automatic test_fill_and_refuse();
        repeat (90) send_random(85, 2);
    endtask

    // Pop-heavy traffic empties the queue and keeps popping from it.
    task automatic test_drain_and_refuse();
        repeat (90) send_random(5, 82);
    endtask

    // Alternating biases sweep the occupancy up and down, wrapping both ends.
    task automatic test_random_mix(input int blocks);
        int b;
        for (b = 0; b < blocks; b++)
        begin
            no_gaps = (b % 5 == 4);
            case (b % 4)
                0: repeat (100) send_random(60, 22);
                1: repeat (100) send_random(20, 62);
                default: repeat (100) send_random(40, 40);
            endcase
        end
        no_gaps = 1'b0;
    endtask

    // Receiver side: stretches of stalls of varied length between free stretches.
    always @(posedge clk)
    begin
        if (stall_hold == 0)
        begin
            stall_on = ($urandom_range(0, 2) == 0);
            stall_hold = stall_on ? 1 + pick_gap() : int'($urandom_range(1, 60));
        end
        stall_hold--;
        out_stall <= stall_on;
    end

    always @(posedge clk)
    begin
        deque_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result item: result_value %0d", result_value);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (result_value !== want.result_value)
                begin
                    $error("result_value: expected %0d, got %0d",
                           want.result_value, result_value);
                    error_count++;
                end
                if (refused !== want.refused)
                begin
                    $error("refused: expected %0d, got %0d", want.refused, refused);
                    error_count++;
                end
                if (occupancy !== want.occupancy)
                begin
                    $error("occupancy: expected %0d, got %0d", want.occupancy, occupancy);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        test_corner_cases();
        test_fill_and_refuse();
        wait_for_results();
        test_drain_and_refuse();
        test_random_mix(15);
        wait_for_results();
        repeat (QUEUE_DEPTH + 16) @(posedge clk);
        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
